FILE: src/fba_pkg.sv
// ----------------------------------------------------------------------------
// fba_pkg
// Shared types and constants of the frame bitmap allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package fba_pkg;

   // request kinds
   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   // result status codes
   localparam logic [1:0] STAT_OK       = 2'd0;
   localparam logic [1:0] STAT_NO_FRAME = 2'd1;
   localparam logic [1:0] STAT_RANGE    = 2'd2;

   // configuration register indexes
   localparam int         CSR_IDX_W        = 1;
   localparam logic [0:0] CSR_BASE_ADDRESS = 1'b0;
   localparam logic [0:0] CSR_FRAME_COUNT  = 1'b1;

   localparam logic [31:0] FAIL_ADDR      = 32'hFFFF_FFFF;
   localparam int          FRAME_SHIFT    = 12;
   localparam int          BITS_PER_WORD  = 32;
   localparam int          BIT_IDX_W      = 5;
   localparam logic [12:0] FRAME_COUNT_RST = 13'd4096;

   // configuration as seen by the sequencer
   typedef struct packed {
      logic [31:0] base_address;
      logic [31:0] eff_count;     // frame_count saturated at MAX_FRAMES
   } cfg_type;

   // result of one pass of the free-bit finder over a bitmap word
   typedef struct packed {
      logic                 found;     // a usable free bit exists
      logic                 last;      // word holds the last managed frame
      logic [BIT_IDX_W-1:0] bit_idx;   // lowest usable free bit
      logic [31:0]          set_mask;  // one-hot of bit_idx
   } find_type;

endpackage

`default_nettype wire

FILE: src/fba_if.sv
// ----------------------------------------------------------------------------
// fba_if
// Valid/ready channels of the frame bitmap allocator.
// ----------------------------------------------------------------------------
`default_nettype none

interface fba_req_if;
   logic        valid;
   logic        ready;
   logic        op;
   logic [31:0] frame_address;
   modport source (output valid, output op, output frame_address, input ready);
   modport sink   (input valid, input op, input frame_address, output ready);
endinterface

interface fba_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] alloc_address;
   logic [1:0]  status;
   modport source (output valid, output alloc_address, output status, input ready);
   modport sink   (input valid, input alloc_address, input status, output ready);
endinterface

interface fba_csr_if;
   logic        valid;
   logic        ready;
   logic [0:0]  index;
   logic [31:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: src/fba_csr_regs.sv
// ----------------------------------------------------------------------------
// fba_csr_regs
// Configuration registers and saturated effective frame count.
// ----------------------------------------------------------------------------
`default_nettype none

module fba_csr_regs
   import fba_pkg::*;
#(
   parameter int MAX_FRAMES = 4096
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        wr_valid,
   output logic             wr_ready,
   input  wire logic [0:0]  wr_index,
   input  wire logic [31:0] wr_data,
   output cfg_type          cfg
);

   logic [31:0] base_ff;
   logic [12:0] count_ff;
   logic [31:0] count32;

   assign wr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff  <= '0;
         count_ff <= FRAME_COUNT_RST;
      end else if (wr_valid) begin
         unique case (wr_index)
            CSR_BASE_ADDRESS: base_ff  <= wr_data;
            CSR_FRAME_COUNT:  count_ff <= wr_data[12:0];
            default: ;
         endcase
      end
   end

   assign count32          = 32'(count_ff);
   assign cfg.base_address = base_ff;
   assign cfg.eff_count    = (count32 > 32'(MAX_FRAMES)) ? 32'(MAX_FRAMES) : count32;

endmodule

`default_nettype wire

FILE: src/fba_bitmap_ram.sv
// ----------------------------------------------------------------------------
// fba_bitmap_ram
// Used-frame bitmap, 32 frames per word, one write and one registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module fba_bitmap_ram #(
   parameter int WORDS = 128,
   parameter int AW    = 7
) (
   input  wire logic          clock,
   input  wire logic          we,
   input  wire logic [AW-1:0] waddr,
   input  wire logic [31:0]   wdata,
   input  wire logic [AW-1:0] raddr,
   output logic [31:0]        rdata
);

   logic [31:0] mem [WORDS];
   logic [31:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

FILE: src/fba_free_finder.sv
// ----------------------------------------------------------------------------
// fba_free_finder
// Lowest free bit of a bitmap word, limited to frames below the count.
// ----------------------------------------------------------------------------
`default_nettype none

module fba_free_finder
   import fba_pkg::*;
(
   input  wire logic [31:0] word,
   input  wire logic [31:0] word_base,   // frame index of bit 0
   input  wire logic [31:0] eff_count,
   output find_type         result
);

   logic [31:0] remain;
   logic        full;
   logic [31:0] valid_mask;
   logic [31:0] free_bits;
   logic [31:0] lowest;
   logic [BIT_IDX_W-1:0] idx;

   // word_base stays below eff_count while scanning, unless a csr write lowers the count
   assign remain     = eff_count - word_base;
   assign full       = (remain >= 32'(BITS_PER_WORD));
   assign valid_mask = full ? '1 : ((32'd1 << remain[BIT_IDX_W-1:0]) - 32'd1);
   assign free_bits  = ~word & valid_mask;
   assign lowest     = free_bits & (~free_bits + 32'd1);

   always_comb begin
      idx = '0;
      for (int b = 0; b < BITS_PER_WORD; b++) begin
         idx = idx | (lowest[b] ? BIT_IDX_W'(b) : '0);
      end
   end

   assign result.found    = |free_bits;
   assign result.last     = ~full | (remain == 32'(BITS_PER_WORD));
   assign result.bit_idx  = idx;
   assign result.set_mask = lowest;

endmodule

`default_nettype wire

FILE: src/frame_bitmap_allocator_core.sv
// ----------------------------------------------------------------------------
// frame_bitmap_allocator_core
// Page-frame allocator over a used-frame bitmap with a preallocated batch.
// ----------------------------------------------------------------------------
// Frames are 4096 bytes; frame i sits at base_address + i*4096 (mod 2^32).
// Allocates are served from a batch store of BATCH_SIZE frame indexes; when
// the batch is empty a refill takes the lowest free frames below the
// effective count (frame_count saturated at MAX_FRAMES) and marks them used.
// A refill that runs out answers 0xFFFFFFFF / status 1, keeps the frames it
// took marked, and leaves the batch empty. A free turns an address into
// (addr - base) >> 12 and clears that bit, or answers 0xFFFFFFFF / status 2
// when out of range. One request is worked at a time, req ready only in idle.
// Steps: a free reads the bitmap word and writes it back with the bit
// cleared; an allocate from a filled batch reads the batch entry at the
// pointer; a refill reads each bitmap word in turn and takes its free frames
// one at a time, all through the one free-bit finder and the single bitmap
// read port. After reset a clearing pass writes the bitmap one word a cycle,
// all ceil(MAX_FRAMES/32) words (128 at the default), with req ready low;
// csr writes are taken at any time.
// ----------------------------------------------------------------------------
`default_nettype none

module frame_bitmap_allocator_core
   import fba_pkg::*;
#(
   parameter int MAX_FRAMES = 4096,
   parameter int BATCH_SIZE = 20
) (
   input  wire logic clock,
   input  wire logic reset,
   fba_req_if.sink   req_bus,
   fba_rsp_if.source rsp_bus,
   fba_csr_if.sink   csr_bus
);

   localparam int MAP_WORDS = (MAX_FRAMES + BITS_PER_WORD - 1) / BITS_PER_WORD;
   localparam int WW  = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
   localparam int FW  = $clog2(MAX_FRAMES);
   localparam int PW  = $clog2(BATCH_SIZE + 1);
   localparam int BIW = (BATCH_SIZE > 1) ? $clog2(BATCH_SIZE) : 1;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_FREE_RD,
      S_FREE_WR,
      S_SCAN_RD,
      S_SCAN_LD,
      S_SCAN,
      S_BATCH_WAIT,
      S_SERVE,
      S_RESP
   } state_type;

   state_type state_ff;

   cfg_type  cfg;
   find_type find;

   // sequencer registers
   logic [WW-1:0]        clr_ptr_ff;
   logic [WW-1:0]        word_idx_ff;
   logic [31:0]          word_ff;
   logic [PW-1:0]        fill_ff;
   logic [PW-1:0]        ptr_ff;
   logic [WW-1:0]        free_word_ff;
   logic [BIT_IDX_W-1:0] free_bit_ff;
   logic [31:0]          res_addr_ff;
   logic [1:0]           res_status_ff;
   logic                 rsp_valid_ff;
   logic [31:0]          rsp_addr_ff;
   logic [1:0]           rsp_status_ff;

   // bitmap port
   logic          map_we;
   logic [WW-1:0] map_waddr;
   logic [31:0]   map_wdata;
   logic [WW-1:0] map_raddr;
   logic [31:0]   map_rdata;

   // batch store
   logic [FW-1:0]  batch_mem [BATCH_SIZE];
   logic [FW-1:0]  batch_rd_ff;
   logic [BIW-1:0] batch_raddr;
   logic           batch_we;
   logic [FW-1:0]  batch_wdata;

   logic        req_xfer;
   logic [31:0] free_offset;
   logic [31:0] free_index;
   logic [31:0] word_base;
   logic        rsp_free;

   fba_csr_regs #(
      .MAX_FRAMES (MAX_FRAMES)
   ) u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (csr_bus.valid),
      .wr_ready (csr_bus.ready),
      .wr_index (csr_bus.index),
      .wr_data  (csr_bus.data),
      .cfg      (cfg)
   );

   fba_bitmap_ram #(
      .WORDS (MAP_WORDS),
      .AW    (WW)
   ) u_map (
      .clock (clock),
      .we    (map_we),
      .waddr (map_waddr),
      .wdata (map_wdata),
      .raddr (map_raddr),
      .rdata (map_rdata)
   );

   assign word_base = 32'(word_idx_ff) << BIT_IDX_W;

   fba_free_finder u_find (
      .word      (word_ff),
      .word_base (word_base),
      .eff_count (cfg.eff_count),
      .result    (find)
   );

   assign req_bus.ready = (state_ff == S_IDLE);
   assign req_xfer      = req_bus.valid && req_bus.ready;

   // free path: offset wraps before the frame shift
   assign free_offset = req_bus.frame_address - cfg.base_address;
   assign free_index  = free_offset >> FRAME_SHIFT;

   // output register frees up this cycle
   assign rsp_free = !rsp_valid_ff || rsp_bus.ready;

   // bitmap write and read selection
   always_comb begin
      map_we    = 1'b0;
      map_waddr = word_idx_ff;
      map_wdata = word_ff | find.set_mask;
      map_raddr = word_idx_ff;
      unique case (state_ff)
         S_CLEAR: begin
            map_we    = 1'b1;
            map_waddr = clr_ptr_ff;
            map_wdata = '0;
         end
         S_FREE_RD: begin
            map_raddr = free_word_ff;
         end
         S_FREE_WR: begin
            map_we    = 1'b1;
            map_waddr = free_word_ff;
            map_wdata = map_rdata & ~(32'd1 << free_bit_ff);
         end
         S_SCAN: begin
            map_we = find.found;
         end
         default: ;
      endcase
   end

   // batch store: written during refill, read at the batch pointer
   assign batch_we    = (state_ff == S_SCAN) && find.found;
   assign batch_wdata = FW'(word_base | 32'(find.bit_idx));
   assign batch_raddr = (ptr_ff < PW'(BATCH_SIZE)) ? ptr_ff[BIW-1:0] : '0;

   always_ff @(posedge clock) begin
      if (batch_we) begin
         batch_mem[fill_ff[BIW-1:0]] <= batch_wdata;
      end
      batch_rd_ff <= batch_mem[batch_raddr];
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ptr_ff   <= '0;
         ptr_ff       <= PW'(BATCH_SIZE);
         rsp_valid_ff <= 1'b0;
      end else begin
         // output register: load a finished result, else drop on transfer
         if (state_ff == S_RESP && rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            S_CLEAR: begin
               clr_ptr_ff <= clr_ptr_ff + WW'(1);
               if (clr_ptr_ff == WW'(MAP_WORDS - 1)) begin
                  state_ff <= S_IDLE;
               end
            end

            S_IDLE: begin
               if (req_xfer) begin
                  if (req_bus.op == OP_FREE) begin
                     free_word_ff <= WW'(free_index >> BIT_IDX_W);
                     free_bit_ff  <= free_index[BIT_IDX_W-1:0];
                     if (free_index >= cfg.eff_count) begin
                        res_addr_ff   <= FAIL_ADDR;
                        res_status_ff <= STAT_RANGE;
                        state_ff      <= S_RESP;
                     end else begin
                        state_ff <= S_FREE_RD;
                     end
                  end else if (ptr_ff < PW'(BATCH_SIZE)) begin
                     state_ff <= S_SERVE;
                  end else begin
                     // batch empty: start a refill from frame zero
                     fill_ff     <= '0;
                     word_idx_ff <= '0;
                     if (cfg.eff_count == '0) begin
                        res_addr_ff   <= FAIL_ADDR;
                        res_status_ff <= STAT_NO_FRAME;
                        state_ff      <= S_RESP;
                     end else begin
                        state_ff <= S_SCAN_RD;
                     end
                  end
               end
            end

            S_FREE_RD: begin
               state_ff <= S_FREE_WR;
            end

            S_FREE_WR: begin
               res_addr_ff   <= '0;
               res_status_ff <= STAT_OK;
               state_ff      <= S_RESP;
            end

            S_SCAN_RD: begin
               state_ff <= S_SCAN_LD;
            end

            S_SCAN_LD: begin
               word_ff  <= map_rdata;
               state_ff <= S_SCAN;
            end

            S_SCAN: begin
               priority if (find.found) begin
                  // frames below this one are all used, keep the word
                  word_ff <= word_ff | find.set_mask;
                  fill_ff <= fill_ff + PW'(1);
                  if (fill_ff == PW'(BATCH_SIZE - 1)) begin
                     ptr_ff   <= '0;
                     state_ff <= S_BATCH_WAIT;
                  end
               end else if (find.last) begin
                  res_addr_ff   <= FAIL_ADDR;
                  res_status_ff <= STAT_NO_FRAME;
                  state_ff      <= S_RESP;
               end else begin
                  word_idx_ff <= word_idx_ff + WW'(1);
                  state_ff    <= S_SCAN_RD;
               end
            end

            S_BATCH_WAIT: begin
               // batch read of entry zero lands at this edge
               state_ff <= S_SERVE;
            end

            S_SERVE: begin
               res_addr_ff   <= cfg.base_address + (32'(batch_rd_ff) << FRAME_SHIFT);
               res_status_ff <= STAT_OK;
               ptr_ff        <= ptr_ff + PW'(1);
               state_ff      <= S_RESP;
            end

            S_RESP: begin
               if (rsp_free) begin
                  rsp_addr_ff   <= res_addr_ff;
                  rsp_status_ff <= res_status_ff;
                  state_ff      <= S_IDLE;
               end
            end

            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.alloc_address = rsp_addr_ff;
   assign rsp_bus.status        = rsp_status_ff;

endmodule

`default_nettype wire

FILE: src/fba_checker.sv
// ----------------------------------------------------------------------------
// fba_checker
// Port-level checks of the frame bitmap allocator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module fba_checker
   import fba_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [31:0] rsp_alloc_address,
   input wire logic [1:0]  rsp_status
);

   logic       req_xfer;
   logic       rsp_xfer;
   logic [1:0] pend_ff;

   assign req_xfer = req_valid && req_ready;
   assign rsp_xfer = rsp_valid && rsp_ready;

   // requests taken whose result has not been transferred
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_ff + 2'(req_xfer) - 2'(rsp_xfer);
      end
   end

   a_pending_bound: assert property (@(posedge clock) disable iff (reset)
      pend_ff != 2'd3)
      else $error("more than two requests outstanding");

   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> !req_ready)
      else $error("request taken while previous one in progress");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == STAT_OK || rsp_status == STAT_NO_FRAME ||
                     rsp_status == STAT_RANGE))
      else $error("undefined status code");

   a_fail_address: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != STAT_OK) |-> rsp_alloc_address == FAIL_ADDR)
      else $error("error result without failure address");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_alloc_address) && $stable(rsp_status)))
      else $error("stalled result changed");

endmodule

bind frame_bitmap_allocator_core fba_checker u_fba_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_bus.valid),
   .req_ready         (req_bus.ready),
   .rsp_valid         (rsp_bus.valid),
   .rsp_ready         (rsp_bus.ready),
   .rsp_alloc_address (rsp_bus.alloc_address),
   .rsp_status        (rsp_bus.status)
);

`default_nettype wire
